>>> hw/rtl/dea_pkg.sv
`default_nettype none
package dea_pkg;

  localparam int MAX_NODES_DEF = 8;
  localparam int DW = 48;
  localparam int IW = 32;

  localparam logic [2:0] ACT_CLEAR      = 3'd0;
  localparam logic [2:0] ACT_LOAD_POINT = 3'd1;
  localparam logic [2:0] ACT_LOAD_NODE  = 3'd2;
  localparam logic [2:0] ACT_ACCUM      = 3'd3;
  localparam logic [2:0] ACT_READ       = 3'd4;

  typedef enum logic [3:0] {
    DP_NOP, DP_MUL, DP_ADD, DP_RD_I, DP_RD_J, DP_RES_ADD, DP_K_WR, DP_ROW_END, DP_COL_END
  } dp_op_t;

  typedef enum logic [4:0] {
    S_RATE, S_GUX, S_GUY, S_GUZ, S_A, S_B, S_TA, S_TB,
    S_NI, S_GIX, S_GIY, S_GIZ, S_NJ, S_GJX, S_GJY, S_GJZ,
    S_DU, S_T0, S_T1, S_T2
  } slot_t;

  typedef struct packed {
    dp_op_t op;
    slot_t  a;
    slot_t  b;
    slot_t  dst;
  } uop_t;

  typedef struct packed {
    logic   accept;
    logic   go;
    dp_op_t op;
    slot_t  a;
    slot_t  b;
    slot_t  dst;
    logic   emit;
    logic   emit_read;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic jac;
  } dp_stat_t;

  localparam logic [4:0] P_ROW = 5'd0;
  localparam logic [4:0] P_COL = 5'd11;

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] x,
                                               input logic signed [DW-1:0] y);
    logic signed [DW:0] s;
    s = {x[DW-1], x} + {y[DW-1], y};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return s[DW-1:0];
  endfunction

  function automatic uop_t uop_at(input logic [4:0] pc);
    uop_t u;
    u = '{op: DP_NOP, a: S_T0, b: S_T0, dst: S_T0};
    case (pc)
      5'd0:  u = '{op: DP_RD_I,    a: S_T0,   b: S_T0,  dst: S_T0};
      5'd1:  u = '{op: DP_MUL,     a: S_GUX,  b: S_GIX, dst: S_T0};
      5'd2:  u = '{op: DP_MUL,     a: S_GUY,  b: S_GIY, dst: S_T1};
      5'd3:  u = '{op: DP_ADD,     a: S_T0,   b: S_T1,  dst: S_T0};
      5'd4:  u = '{op: DP_MUL,     a: S_GUZ,  b: S_GIZ, dst: S_T1};
      5'd5:  u = '{op: DP_ADD,     a: S_T0,   b: S_T1,  dst: S_DU};
      5'd6:  u = '{op: DP_MUL,     a: S_RATE, b: S_NI,  dst: S_T0};
      5'd7:  u = '{op: DP_MUL,     a: S_A,    b: S_DU,  dst: S_T1};
      5'd8:  u = '{op: DP_ADD,     a: S_T0,   b: S_T1,  dst: S_T0};
      5'd9:  u = '{op: DP_RES_ADD, a: S_T0,   b: S_T0,  dst: S_T0};
      5'd10: u = '{op: DP_ROW_END, a: S_T0,   b: S_T0,  dst: S_T0};
      5'd11: u = '{op: DP_RD_J,    a: S_T0,   b: S_T0,  dst: S_T0};
      5'd12: u = '{op: DP_MUL,     a: S_NJ,   b: S_NI,  dst: S_T0};
      5'd13: u = '{op: DP_MUL,     a: S_T0,   b: S_TB,  dst: S_T0};
      5'd14: u = '{op: DP_MUL,     a: S_B,    b: S_NJ,  dst: S_T1};
      5'd15: u = '{op: DP_MUL,     a: S_T1,   b: S_DU,  dst: S_T1};
      5'd16: u = '{op: DP_MUL,     a: S_T1,   b: S_TA,  dst: S_T1};
      5'd17: u = '{op: DP_ADD,     a: S_T0,   b: S_T1,  dst: S_T0};
      5'd18: u = '{op: DP_MUL,     a: S_GJX,  b: S_GIX, dst: S_T1};
      5'd19: u = '{op: DP_MUL,     a: S_GJY,  b: S_GIY, dst: S_T2};
      5'd20: u = '{op: DP_ADD,     a: S_T1,   b: S_T2,  dst: S_T1};
      5'd21: u = '{op: DP_MUL,     a: S_GJZ,  b: S_GIZ, dst: S_T2};
      5'd22: u = '{op: DP_ADD,     a: S_T1,   b: S_T2,  dst: S_T1};
      5'd23: u = '{op: DP_MUL,     a: S_A,    b: S_T1,  dst: S_T1};
      5'd24: u = '{op: DP_MUL,     a: S_T1,   b: S_TA,  dst: S_T1};
      5'd25: u = '{op: DP_ADD,     a: S_T0,   b: S_T1,  dst: S_T0};
      5'd26: u = '{op: DP_K_WR,    a: S_T0,   b: S_T0,  dst: S_T0};
      5'd27: u = '{op: DP_COL_END, a: S_T0,   b: S_T0,  dst: S_T0};
      default: u = '{op: DP_NOP,   a: S_T0,   b: S_T0,  dst: S_T0};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dea_ram.sv
`default_nettype none
module dea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hw/rtl/dea_mul.sv
`default_nettype none
module dea_mul (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [dea_pkg::DW-1:0]    a,
  input  wire logic signed [dea_pkg::DW-1:0]    b,
  output logic                                  done,
  output logic signed [dea_pkg::DW-1:0]         p
);

  localparam int DW = dea_pkg::DW;
  localparam int HW = DW / 2;
  localparam int PW = 2 * DW;
  localparam int MW = PW - 24;

  logic              busy_r, rnd_r, done_r, neg_r;
  logic [1:0]        step_r;
  logic [DW-1:0]     ma_r, mb_r;
  logic [PW-1:0]     acc_r;
  logic signed [DW-1:0] p_r;

  logic [HW-1:0]     ah, bh;
  logic [DW-1:0]     pp;
  logic [PW-1:0]     pp_sh;
  logic [PW-1:0]     t;
  logic [MW-1:0]     mag;
  logic [MW-1:0]     lim;
  logic signed [DW-1:0] res;

  always_comb begin
    ah = step_r[1] ? ma_r[DW-1:HW] : ma_r[HW-1:0];
    bh = step_r[0] ? mb_r[DW-1:HW] : mb_r[HW-1:0];
    pp = ah * bh;
    case (step_r)
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << (2 * HW);
      default: pp_sh = PW'(pp) << HW;
    endcase
    t   = acc_r + (PW'(1) << 23);
    mag = t[PW-1:24];
    if (neg_r) begin
      lim = MW'(1) << (DW - 1);
      res = (mag > lim) ? {1'b1, {(DW-1){1'b0}}} : DW'(0) - mag[DW-1:0];
    end else begin
      lim = (MW'(1) << (DW - 1)) - MW'(1);
      res = (mag > lim) ? {1'b0, {(DW-1){1'b1}}} : mag[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ma_r   <= a[DW-1] ? DW'(0) - a : a;
        mb_r   <= b[DW-1] ? DW'(0) - b : b;
        neg_r  <= a[DW-1] ^ b[DW-1];
        acc_r  <= '0;
        step_r <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_r + pp_sh;
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        p_r    <= res;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule
`default_nettype wire

>>> hw/rtl/dea_datapath.sv
`default_nettype none
module dea_datapath #(
  parameter int MAX_NODES = dea_pkg::MAX_NODES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire dea_pkg::dp_cmd_t                   cmd,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]     row_i,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]     col_j,
  input  wire logic [2:0]                         in_action,
  input  wire logic [2:0]                         in_row_index,
  input  wire logic [2:0]                         in_col_index,
  input  wire logic signed [31:0]                 in_value,
  input  wire logic signed [31:0]                 in_grad_x,
  input  wire logic signed [31:0]                 in_grad_y,
  input  wire logic signed [31:0]                 in_grad_z,
  input  wire logic signed [31:0]                 in_coef_a,
  input  wire logic signed [31:0]                 in_coef_b,
  input  wire logic signed [31:0]                 in_tan_a,
  input  wire logic signed [31:0]                 in_tan_b,
  input  wire logic                               in_with_jacobian,
  output dea_pkg::dp_stat_t                       stat,
  output logic signed [47:0]                      out_residual_entry,
  output logic signed [47:0]                      out_stiffness_entry
);

  localparam int DW = dea_pkg::DW;
  localparam int IW = dea_pkg::IW;
  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int KD = MAX_NODES * MAX_NODES;
  localparam int KW = (KD > 1) ? $clog2(KD) : 1;

  logic signed [IW-1:0] pd_r [8];
  logic                 jac_r;
  logic signed [IW-1:0] ni_r, nj_r;
  logic signed [IW-1:0] gi_r [3];
  logic signed [IW-1:0] gj_r [3];
  logic signed [DW-1:0] du_r;
  logic signed [DW-1:0] t_r [3];
  logic signed [DW-1:0] res_r [MAX_NODES];
  logic [KD-1:0]        kv_r;
  logic                 kvq_r, kok_r;
  logic signed [DW-1:0] rd_res_r;
  logic                 done_r, rd_pend_r, rd_j_r;
  dea_pkg::slot_t       dst_r;
  logic signed [DW-1:0] out_res_r, out_k_r;

  logic                 row_ok, col_ok;
  logic [NW-1:0]        row_n, i_idx, j_idx, res_a;
  logic [KW-1:0]        k_acc, k_rd;
  logic signed [DW-1:0] res_q, opa, opb, k_old, k_new;
  logic                 sh_we, sh_re, k_we, k_re;
  logic [4*IW-1:0]      sh_wdata, sh_rdata;
  logic [NW-1:0]        sh_raddr;
  logic [KW-1:0]        k_raddr;
  logic [DW-1:0]        k_rdata;
  logic                 mul_start, mul_done;
  logic signed [DW-1:0] mul_p;
  logic                 wr_en;
  dea_pkg::slot_t       wr_slot;
  logic signed [DW-1:0] wr_val;

  function automatic logic signed [DW-1:0] slot_val(input dea_pkg::slot_t s);
    logic signed [DW-1:0] v;
    unique case (s)
      dea_pkg::S_RATE: v = DW'(pd_r[0]);
      dea_pkg::S_GUX:  v = DW'(pd_r[1]);
      dea_pkg::S_GUY:  v = DW'(pd_r[2]);
      dea_pkg::S_GUZ:  v = DW'(pd_r[3]);
      dea_pkg::S_A:    v = DW'(pd_r[4]);
      dea_pkg::S_B:    v = DW'(pd_r[5]);
      dea_pkg::S_TA:   v = DW'(pd_r[6]);
      dea_pkg::S_TB:   v = DW'(pd_r[7]);
      dea_pkg::S_NI:   v = DW'(ni_r);
      dea_pkg::S_GIX:  v = DW'(gi_r[0]);
      dea_pkg::S_GIY:  v = DW'(gi_r[1]);
      dea_pkg::S_GIZ:  v = DW'(gi_r[2]);
      dea_pkg::S_NJ:   v = DW'(nj_r);
      dea_pkg::S_GJX:  v = DW'(gj_r[0]);
      dea_pkg::S_GJY:  v = DW'(gj_r[1]);
      dea_pkg::S_GJZ:  v = DW'(gj_r[2]);
      dea_pkg::S_DU:   v = du_r;
      dea_pkg::S_T0:   v = t_r[0];
      dea_pkg::S_T1:   v = t_r[1];
      dea_pkg::S_T2:   v = t_r[2];
      default:         v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    row_ok   = 32'(in_row_index) < MAX_NODES;
    col_ok   = 32'(in_col_index) < MAX_NODES;
    row_n    = NW'(in_row_index);
    i_idx    = row_i[NW-1:0];
    j_idx    = col_j[NW-1:0];
    k_acc    = KW'(32'(row_i) * MAX_NODES + 32'(col_j));
    k_rd     = KW'(32'(in_row_index) * MAX_NODES + 32'(in_col_index));
    res_a    = cmd.accept ? row_n : i_idx;
    res_q    = res_r[res_a];
    opa      = slot_val(cmd.a);
    opb      = slot_val(cmd.b);
    k_old    = kvq_r ? $signed(k_rdata) : '0;
    k_new    = dea_pkg::sadd(k_old, opa);

    sh_we    = cmd.accept && (in_action == dea_pkg::ACT_LOAD_NODE) && row_ok;
    sh_wdata = {in_value, in_grad_x, in_grad_y, in_grad_z};
    sh_re    = cmd.go && ((cmd.op == dea_pkg::DP_RD_I) || (cmd.op == dea_pkg::DP_RD_J));
    sh_raddr = (cmd.op == dea_pkg::DP_RD_J) ? j_idx : i_idx;

    k_we     = cmd.go && (cmd.op == dea_pkg::DP_K_WR);
    k_re     = (cmd.go && (cmd.op == dea_pkg::DP_RD_J)) ||
               (cmd.accept && (in_action == dea_pkg::ACT_READ));
    k_raddr  = cmd.accept ? k_rd : k_acc;

    mul_start = cmd.go && (cmd.op == dea_pkg::DP_MUL);

    wr_en    = (cmd.go && (cmd.op == dea_pkg::DP_ADD)) || mul_done;
    wr_slot  = mul_done ? dst_r : cmd.dst;
    wr_val   = mul_done ? mul_p : dea_pkg::sadd(opa, opb);
  end

  dea_ram #(
    .WIDTH (4 * IW),
    .DEPTH (MAX_NODES)
  ) u_shape_ram (
    .clk   (clk),
    .we    (sh_we),
    .waddr (row_n),
    .wdata (sh_wdata),
    .re    (sh_re),
    .raddr (sh_raddr),
    .rdata (sh_rdata)
  );

  dea_ram #(
    .WIDTH (DW),
    .DEPTH (KD)
  ) u_stiff_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_acc),
    .wdata (k_new),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  dea_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) begin
        pd_r[k] <= '0;
      end
      for (int k = 0; k < MAX_NODES; k++) begin
        res_r[k] <= '0;
      end
      jac_r     <= 1'b0;
      kv_r      <= '0;
      done_r    <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      done_r <= 1'b0;

      if (cmd.accept) begin
        case (in_action)
          dea_pkg::ACT_CLEAR: begin
            for (int k = 0; k < MAX_NODES; k++) begin
              res_r[k] <= '0;
            end
            kv_r <= '0;
          end
          dea_pkg::ACT_LOAD_POINT: begin
            pd_r[0] <= in_value;
            pd_r[1] <= in_grad_x;
            pd_r[2] <= in_grad_y;
            pd_r[3] <= in_grad_z;
            pd_r[4] <= in_coef_a;
            pd_r[5] <= in_coef_b;
            pd_r[6] <= in_tan_a;
            pd_r[7] <= in_tan_b;
            jac_r   <= in_with_jacobian;
          end
          dea_pkg::ACT_READ: begin
            rd_res_r <= row_ok ? res_q : '0;
            kok_r    <= row_ok && col_ok && kv_r[k_rd];
          end
          default: ;
        endcase
      end

      if (cmd.go) begin
        case (cmd.op) inside
          dea_pkg::DP_MUL: dst_r <= cmd.dst;
          dea_pkg::DP_RES_ADD: begin
            res_r[i_idx] <= dea_pkg::sadd(res_q, opa);
            done_r       <= 1'b1;
          end
          dea_pkg::DP_K_WR: begin
            kv_r[k_acc] <= 1'b1;
            done_r      <= 1'b1;
          end
          dea_pkg::DP_RD_I, dea_pkg::DP_RD_J: begin
            rd_pend_r <= 1'b1;
            rd_j_r    <= (cmd.op == dea_pkg::DP_RD_J);
            kvq_r     <= kv_r[k_acc];
          end
          default: done_r <= 1'b1;
        endcase
      end

      if (rd_pend_r) begin
        rd_pend_r <= 1'b0;
        done_r    <= 1'b1;
        if (rd_j_r) begin
          nj_r    <= sh_rdata[4*IW-1:3*IW];
          gj_r[0] <= sh_rdata[3*IW-1:2*IW];
          gj_r[1] <= sh_rdata[2*IW-1:IW];
          gj_r[2] <= sh_rdata[IW-1:0];
        end else begin
          ni_r    <= sh_rdata[4*IW-1:3*IW];
          gi_r[0] <= sh_rdata[3*IW-1:2*IW];
          gi_r[1] <= sh_rdata[2*IW-1:IW];
          gi_r[2] <= sh_rdata[IW-1:0];
        end
      end

      if (mul_done) begin
        done_r <= 1'b1;
      end

      if (wr_en) begin
        case (wr_slot)
          dea_pkg::S_DU: du_r   <= wr_val;
          dea_pkg::S_T0: t_r[0] <= wr_val;
          dea_pkg::S_T1: t_r[1] <= wr_val;
          dea_pkg::S_T2: t_r[2] <= wr_val;
          default: ;
        endcase
      end

      if (cmd.emit) begin
        out_res_r <= cmd.emit_read ? rd_res_r : '0;
        out_k_r   <= (cmd.emit_read && kok_r) ? $signed(k_rdata) : '0;
      end
    end
  end

  assign stat.done           = done_r;
  assign stat.jac            = jac_r;
  assign out_residual_entry  = out_res_r;
  assign out_stiffness_entry = out_k_r;

endmodule
`default_nettype wire

>>> hw/rtl/dea_ctrl.sv
`default_nettype none
module dea_ctrl #(
  parameter int MAX_NODES = dea_pkg::MAX_NODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic [2:0]                       in_action,
  output logic                                  in_stall,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  input  wire logic [3:0]                       nodes,
  input  wire dea_pkg::dp_stat_t                stat,
  output dea_pkg::dp_cmd_t                      cmd,
  output logic [$clog2(MAX_NODES+1)-1:0]        row_i,
  output logic [$clog2(MAX_NODES+1)-1:0]        col_j
);

  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT, ST_FINISH} state_t;

  state_t        state_r;
  logic [4:0]    pc_r;
  logic [CW-1:0] i_r, j_r;
  logic          rd_r, out_valid_r;

  logic [CW-1:0]  n_c;
  dea_pkg::uop_t  u;
  logic           accept, emit, last_row, last_col;

  always_comb begin
    n_c      = (32'(nodes) > MAX_NODES) ? CW'(MAX_NODES) : CW'(nodes);
    u        = dea_pkg::uop_at(pc_r);
    accept   = in_valid && (state_r == ST_IDLE);
    emit     = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
    last_row = (32'(i_r) + 1) >= 32'(n_c);
    last_col = (32'(j_r) + 1) >= 32'(n_c);

    cmd.accept    = accept;
    cmd.go        = (state_r == ST_EXEC) && (u.op != dea_pkg::DP_ROW_END) &&
                    (u.op != dea_pkg::DP_COL_END);
    cmd.op        = u.op;
    cmd.a         = u.a;
    cmd.b         = u.b;
    cmd.dst       = u.dst;
    cmd.emit      = emit;
    cmd.emit_read = rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= dea_pkg::P_ROW;
      i_r         <= '0;
      j_r         <= '0;
      rd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            rd_r <= (in_action == dea_pkg::ACT_READ);
            if ((in_action == dea_pkg::ACT_ACCUM) && (n_c != '0)) begin
              i_r     <= '0;
              pc_r    <= dea_pkg::P_ROW;
              state_r <= ST_EXEC;
            end else begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_EXEC: begin
          case (u.op)
            dea_pkg::DP_ROW_END: begin
              if (stat.jac) begin
                j_r  <= '0;
                pc_r <= dea_pkg::P_COL;
              end else if (last_row) begin
                state_r <= ST_FINISH;
              end else begin
                i_r  <= i_r + CW'(1);
                pc_r <= dea_pkg::P_ROW;
              end
            end
            dea_pkg::DP_COL_END: begin
              if (!last_col) begin
                j_r  <= j_r + CW'(1);
                pc_r <= dea_pkg::P_COL;
              end else if (last_row) begin
                state_r <= ST_FINISH;
              end else begin
                i_r  <= i_r + CW'(1);
                pc_r <= dea_pkg::P_ROW;
              end
            end
            default: state_r <= ST_WAIT;
          endcase
        end
        ST_WAIT: begin
          if (stat.done) begin
            pc_r    <= pc_r + 5'd1;
            state_r <= ST_EXEC;
          end
        end
        ST_FINISH: begin
          if (emit) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign row_i     = i_r;
  assign col_j     = j_r;

endmodule
`default_nettype wire

>>> hw/rtl/diffusion_element_assembly.sv
// Quadrature-point element assembly for transient diffusion in signed Q8.24, with 48-bit
// saturating accumulators holding 24 fraction bits. Each input word carries an action: clear
// the residual and stiffness stores, load point data, load one node's shape data, accumulate
// over the nodes in use (register at paddr 0, capped at MAX_NODES) or read one residual and
// one stiffness entry; every word returns exactly one result word, zero unless it was a read.
// One word is worked on at a time. Accumulate is sequenced through a single shared
// multiplier that builds each product from four 24x24 partial products plus a rounding step,
// computing residual rows and, with the Jacobian flag set, stiffness entries. Shape data
// must be loaded for every node in use before accumulating.
`default_nettype none
module diffusion_element_assembly #(
  parameter int MAX_NODES = dea_pkg::MAX_NODES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_action,
  input  wire logic [2:0]         in_row_index,
  input  wire logic [2:0]         in_col_index,
  input  wire logic signed [31:0] in_value,
  input  wire logic signed [31:0] in_grad_x,
  input  wire logic signed [31:0] in_grad_y,
  input  wire logic signed [31:0] in_grad_z,
  input  wire logic signed [31:0] in_coef_a,
  input  wire logic signed [31:0] in_coef_b,
  input  wire logic signed [31:0] in_tan_a,
  input  wire logic signed [31:0] in_tan_b,
  input  wire logic               in_with_jacobian,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      out_residual_entry,
  output logic signed [47:0]      out_stiffness_entry,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [2:0] ADDR_NODES = 3'd0;

  logic [3:0]        nodes_r;
  dea_pkg::dp_cmd_t  cmd;
  dea_pkg::dp_stat_t stat;
  logic [CW-1:0]     row_i, col_j;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r <= 4'd8;
    end else if (psel && penable && pwrite && (paddr == ADDR_NODES)) begin
      nodes_r <= pwdata[3:0];
    end
  end

  assign prdata = (paddr == ADDR_NODES) ? {28'd0, nodes_r} : 32'd0;
  assign pready = 1'b1;

  dea_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .nodes     (nodes_r),
    .stat      (stat),
    .cmd       (cmd),
    .row_i     (row_i),
    .col_j     (col_j)
  );

  dea_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .row_i               (row_i),
    .col_j               (col_j),
    .in_action           (in_action),
    .in_row_index        (in_row_index),
    .in_col_index        (in_col_index),
    .in_value            (in_value),
    .in_grad_x           (in_grad_x),
    .in_grad_y           (in_grad_y),
    .in_grad_z           (in_grad_z),
    .in_coef_a           (in_coef_a),
    .in_coef_b           (in_coef_b),
    .in_tan_a            (in_tan_a),
    .in_tan_b            (in_tan_b),
    .in_with_jacobian    (in_with_jacobian),
    .stat                (stat),
    .out_residual_entry  (out_residual_entry),
    .out_stiffness_entry (out_stiffness_entry)
  );

endmodule
`default_nettype wire
